FILE: rtl/ray_triangle_hit_macros.svh
// Assertion macros for the ray-triangle intersection block.
// Included by modules that carry concurrent checks; clock i_clk, reset i_rst_n.
`ifndef RAY_TRIANGLE_HIT_MACROS_SVH
`define RAY_TRIANGLE_HIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RTH_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ray_triangle_hit check failed");
`define RTH_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ray_triangle_hit check failed");
`else
`define RTH_ASSERT_IMP(lbl, ante, cons)
`define RTH_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/rth_pkg.sv
// Shared types and codes for the ray-triangle intersection block.
// No dependencies.
package rth_pkg;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int LIMIT_WIDTH     = 31;
    localparam int CFG_INDEX_WIDTH = 3;

    typedef logic [2:0]                 t_reason;
    typedef logic [CFG_INDEX_WIDTH-1:0] t_cfg_index;

    localparam t_cfg_index REG_ORIGIN_X   = 3'd0;
    localparam t_cfg_index REG_ORIGIN_Y   = 3'd1;
    localparam t_cfg_index REG_ORIGIN_Z   = 3'd2;
    localparam t_cfg_index REG_DIR_X      = 3'd3;
    localparam t_cfg_index REG_DIR_Y      = 3'd4;
    localparam t_cfg_index REG_DIR_Z      = 3'd5;
    localparam t_cfg_index REG_NEAR_LIMIT = 3'd6;

    localparam t_reason REASON_HIT      = 3'd0;
    localparam t_reason REASON_PARALLEL = 3'd1;
    localparam t_reason REASON_BEHIND   = 3'd2;
    localparam t_reason REASON_U_OUT    = 3'd3;
    localparam t_reason REASON_V_OUT    = 3'd4;
endpackage

FILE: rtl/rth_mul.sv
// Three-stage fixed-point multiplier: floor-shifted product, saturated to WB bits.
// Standalone; instanced by ray_triangle_hit.
module rth_mul #(
    parameter int AW = 33,
    parameter int BW = 48,
    parameter int FB = 16,
    parameter int WB = 48
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [AW-1:0] i_a,
    input  logic signed [BW-1:0] i_b,
    output logic signed [WB-1:0] o_p
);
    localparam int BL = (BW + 1) / 2;
    localparam int BH = BW - BL;
    localparam int PW = AW + BW;
    localparam int EW = PW + WB + 1;
    localparam logic [EW-1:0] SAT_MAX = EW'({(WB-1){1'b1}});
    localparam logic [PW:0]   RND     = (PW+1)'({FB{1'b1}});

    logic [AW-1:0]    r_ma;
    logic [BW-1:0]    r_mb;
    logic             r_neg1;
    logic             r_neg2;
    logic [AW+BL-1:0] r_pl;
    logic [AW+BH-1:0] r_ph;
    logic [PW:0]      w_sum;
    logic [EW-1:0]    w_shr;
    logic [WB-2:0]    w_mag;

    always_comb begin
        w_sum = (PW+1)'(r_pl) + ((PW+1)'(r_ph) << BL) + (r_neg2 ? RND : '0);
        w_shr = EW'(w_sum) >> FB;
        w_mag = (w_shr > SAT_MAX) ? SAT_MAX[WB-2:0] : w_shr[WB-2:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ma   <= i_a[AW-1] ? AW'(-i_a) : AW'(i_a);
            r_mb   <= i_b[BW-1] ? BW'(-i_b) : BW'(i_b);
            r_neg1 <= i_a[AW-1] ^ i_b[BW-1];
            r_pl   <= r_ma * r_mb[BL-1:0];
            r_ph   <= r_ma * r_mb[BW-1:BL];
            r_neg2 <= r_neg1;
            o_p    <= r_neg2 ? -$signed({1'b0, w_mag}) : $signed({1'b0, w_mag});
        end
    end
endmodule

FILE: rtl/rth_div.sv
// Pipelined scaled divider: (num * mul) / den truncated toward zero, one quotient
// bit per stage, magnitude clamped above the coordinate range. Standalone.
module rth_div #(
    parameter int CW = 32,
    parameter int WB = 48
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [WB-1:0] i_num,
    input  logic signed [CW-1:0] i_mul,
    input  logic signed [WB-1:0] i_den,
    output logic signed [CW+1:0] o_q
);
    localparam int MAW = WB - 1;
    localparam int ML  = MAW / 2;
    localparam int MH  = MAW - ML;
    localparam int PW  = MAW + CW;
    localparam int NI  = CW + 1;

    logic [WB-1:0]     w_num_mag;
    logic [WB-1:0]     w_den_mag;
    logic [MAW-1:0]    r_ma;
    logic [CW-1:0]     r_md;
    logic [MAW-1:0]    r_dv1;
    logic [MAW-1:0]    r_dv2;
    logic [MAW-1:0]    r_dv3;
    logic              r_neg1;
    logic              r_neg2;
    logic              r_neg3;
    logic [ML+CW-1:0]  r_pl;
    logic [MH+CW-1:0]  r_ph;
    logic [PW-1:0]     r_p;
    logic [MAW-1:0]    r_rem [NI];
    logic [NI-1:0]     r_lo  [NI];
    logic [MAW-1:0]    r_dv  [NI];
    logic [NI-1:0]     r_q   [NI+1];
    logic              r_neg [NI+1];
    logic              r_ovf [NI+1];
    logic [NI-1:0]     w_qm;

    assign w_num_mag = i_num[WB-1] ? WB'(-i_num) : WB'(i_num);
    assign w_den_mag = i_den[WB-1] ? WB'(-i_den) : WB'(i_den);
    assign w_qm      = r_ovf[NI] ? '1 : r_q[NI];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ma     <= w_num_mag[MAW-1:0];
            r_md     <= i_mul[CW-1] ? CW'(-i_mul) : CW'(i_mul);
            r_dv1    <= w_den_mag[MAW-1:0];
            r_neg1   <= i_num[WB-1] ^ i_mul[CW-1] ^ i_den[WB-1];
            r_pl     <= r_ma[ML-1:0] * r_md;
            r_ph     <= r_ma[MAW-1:ML] * r_md;
            r_dv2    <= r_dv1;
            r_neg2   <= r_neg1;
            r_p      <= PW'(r_pl) + (PW'(r_ph) << ML);
            r_dv3    <= r_dv2;
            r_neg3   <= r_neg2;
            r_rem[0] <= {1'b0, r_p[PW-1:CW+1]};
            r_ovf[0] <= {1'b0, r_p[PW-1:CW+1]} >= r_dv3;
            r_lo[0]  <= r_p[CW:0];
            r_q[0]   <= '0;
            r_dv[0]  <= r_dv3;
            r_neg[0] <= r_neg3;
            o_q      <= r_neg[NI] ? -$signed({1'b0, w_qm}) : $signed({1'b0, w_qm});
        end
    end

    for (genvar k = 0; k < NI; k++) begin : g_step
        logic [MAW:0] w_trial;
        logic [MAW:0] w_diff;
        logic         w_ge;

        assign w_trial = {r_rem[k], r_lo[k][NI-1]};
        assign w_diff  = w_trial - {1'b0, r_dv[k]};
        assign w_ge    = w_trial >= {1'b0, r_dv[k]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[k+1]   <= {r_q[k][NI-2:0], w_ge};
                r_neg[k+1] <= r_neg[k];
                r_ovf[k+1] <= r_ovf[k];
            end
        end

        if (k < NI - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k+1] <= w_ge ? w_diff[MAW-1:0] : w_trial[MAW-1:0];
                    r_lo[k+1]  <= {r_lo[k][NI-2:0], 1'b0};
                    r_dv[k+1]  <= r_dv[k];
                end
            end
        end
    end
endmodule

FILE: rtl/ray_triangle_hit.sv
// Throughput: one triangle per cycle; the pipeline holds as a whole only while a
// finished result is stalled at the output register.
// Reset clears all valid bits and loads the ray registers with their reset values.
// Uses rth_pkg, rth_mul, rth_div and ray_triangle_hit_macros.svh.
`include "ray_triangle_hit_macros.svh"
module ray_triangle_hit #(
    parameter int COORD_WIDTH = rth_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = rth_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COORD_WIDTH-1:0] i_vertex0_x,
    input  logic signed [COORD_WIDTH-1:0] i_vertex0_y,
    input  logic signed [COORD_WIDTH-1:0] i_vertex0_z,
    input  logic signed [COORD_WIDTH-1:0] i_vertex1_x,
    input  logic signed [COORD_WIDTH-1:0] i_vertex1_y,
    input  logic signed [COORD_WIDTH-1:0] i_vertex1_z,
    input  logic signed [COORD_WIDTH-1:0] i_vertex2_x,
    input  logic signed [COORD_WIDTH-1:0] i_vertex2_y,
    input  logic signed [COORD_WIDTH-1:0] i_vertex2_z,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_hit,
    output rth_pkg::t_reason              o_reason,
    output logic signed [COORD_WIDTH-1:0] o_point_x,
    output logic signed [COORD_WIDTH-1:0] o_point_y,
    output logic signed [COORD_WIDTH-1:0] o_point_z,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  rth_pkg::t_cfg_index           i_cfg_index,
    input  logic [(COORD_WIDTH > rth_pkg::LIMIT_WIDTH ? COORD_WIDTH
                   : rth_pkg::LIMIT_WIDTH)-1:0] i_cfg_data
);
    import rth_pkg::*;

    localparam int W       = COORD_WIDTH;
    localparam int F       = FRAC_BITS;
    localparam int WB      = (W + 16 < 60) ? W + 16 : 60;
    localparam int CMPW    = (WB > LIMIT_WIDTH) ? WB : LIMIT_WIDTH;
    localparam int DIV_LAT = W + 6;
    localparam int NST     = W + 17;
    localparam logic signed [WB:0]  SAT_HI = {2'b00, {(WB-1){1'b1}}};
    localparam logic signed [WB:0]  SAT_LO = -SAT_HI;
    localparam logic signed [W+2:0] PT_HI  = {4'b0000, {(W-1){1'b1}}};
    localparam logic signed [W+2:0] PT_LO  = ~PT_HI;
    localparam logic signed [W-1:0] DIR_Z_RESET = W'(64'd1 << F);

    function automatic logic signed [WB-1:0] f_sat(input logic signed [WB:0] x);
        logic signed [WB:0] y;
        y = (x > SAT_HI) ? SAT_HI : ((x < SAT_LO) ? SAT_LO : x);
        return y[WB-1:0];
    endfunction

    function automatic logic f_nz(input logic signed [WB-1:0] x,
                                  input logic [LIMIT_WIDTH-1:0] lim);
        logic [WB-1:0] m;
        m = x[WB-1] ? WB'(-x) : WB'(x);
        return (x == '0) || (CMPW'(m) < CMPW'(lim));
    endfunction

    logic                   w_en;
    logic [NST-1:0]         r_vld;

    logic signed [W-1:0]    r_org [3];
    logic signed [W-1:0]    r_dir [3];
    logic [LIMIT_WIDTH-1:0] r_lim;

    logic signed [W-1:0]    w_v0 [3];
    logic signed [W-1:0]    w_v1 [3];
    logic signed [W-1:0]    w_v2 [3];
    logic signed [W:0]      w_dirx [3];

    logic signed [W:0]      r_e1 [3];
    logic signed [W:0]      r_e2 [3];
    logic signed [W:0]      r_tv [3];
    logic signed [W:0]      r_e1d [4][3];
    logic signed [W:0]      r_tvd [4][3];

    logic signed [W:0]      w_ca [3][3];
    logic signed [W:0]      w_cb [3][3];
    logic signed [WB-1:0]   w_cp [3][3];
    logic signed [WB-1:0]   w_cm [3][3];
    logic signed [WB-1:0]   r_cr [3][3];

    logic signed [W:0]      w_da [5][3];
    logic signed [WB-1:0]   w_db [5][3];
    logic signed [WB-1:0]   w_dp [5][3];
    logic signed [WB-1:0]   r_s1 [5];
    logic signed [WB-1:0]   r_z  [5];
    logic signed [WB-1:0]   r_dt [5];

    logic signed [WB-1:0]   w_a;
    logic signed [WB-1:0]   w_un;
    logic signed [WB-1:0]   w_vn;
    logic signed [WB-1:0]   w_dd;
    logic signed [WB:0]     w_uv;
    t_reason                w_rsn;
    t_reason                r_rsn [DIV_LAT];

    logic signed [W+1:0]    w_q  [3];
    logic signed [W+2:0]    w_ps [3];
    logic signed [W-1:0]    w_pt [3];

    logic                   r_hit;
    t_reason                r_rsn_o;
    logic signed [W-1:0]    r_pt [3];

    assign w_en        = !(r_vld[NST-1] && i_stall);
    assign o_stall     = r_vld[NST-1] && i_stall;
    assign o_valid     = r_vld[NST-1];
    assign o_cfg_ready = 1'b1;
    assign o_hit       = r_hit;
    assign o_reason    = r_rsn_o;
    assign o_point_x   = r_pt[0];
    assign o_point_y   = r_pt[1];
    assign o_point_z   = r_pt[2];

    assign w_v0[0] = i_vertex0_x;
    assign w_v0[1] = i_vertex0_y;
    assign w_v0[2] = i_vertex0_z;
    assign w_v1[0] = i_vertex1_x;
    assign w_v1[1] = i_vertex1_y;
    assign w_v1[2] = i_vertex1_z;
    assign w_v2[0] = i_vertex2_x;
    assign w_v2[1] = i_vertex2_y;
    assign w_v2[2] = i_vertex2_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org[0] <= '0;
            r_org[1] <= '0;
            r_org[2] <= '0;
            r_dir[0] <= '0;
            r_dir[1] <= '0;
            r_dir[2] <= DIR_Z_RESET;
            r_lim    <= LIMIT_WIDTH'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ORIGIN_X:   r_org[0] <= i_cfg_data[W-1:0];
                REG_ORIGIN_Y:   r_org[1] <= i_cfg_data[W-1:0];
                REG_ORIGIN_Z:   r_org[2] <= i_cfg_data[W-1:0];
                REG_DIR_X:      r_dir[0] <= i_cfg_data[W-1:0];
                REG_DIR_Y:      r_dir[1] <= i_cfg_data[W-1:0];
                REG_DIR_Z:      r_dir[2] <= i_cfg_data[W-1:0];
                REG_NEAR_LIMIT: r_lim    <= i_cfg_data[LIMIT_WIDTH-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NST-2:0], i_valid};
        end
    end

    // edges and origin offset
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_e1[i] <= (W+1)'(w_v1[i]) - (W+1)'(w_v0[i]);
                r_e2[i] <= (W+1)'(w_v2[i]) - (W+1)'(w_v0[i]);
                r_tv[i] <= (W+1)'(r_org[i]) - (W+1)'(w_v0[i]);
            end
            r_e1d[0] <= r_e1;
            r_tvd[0] <= r_tv;
            for (int j = 1; j < 4; j++) begin
                r_e1d[j] <= r_e1d[j-1];
                r_tvd[j] <= r_tvd[j-1];
            end
        end
    end

    // cross products: pvec, plane normal, qvec
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_dirx[i] = (W+1)'(r_dir[i]);
        end
        w_ca[0] = w_dirx;
        w_cb[0] = r_e2;
        w_ca[1] = r_e1;
        w_cb[1] = r_e2;
        w_ca[2] = r_tv;
        w_cb[2] = r_e1;
    end

    for (genvar k = 0; k < 3; k++) begin : g_cross
        for (genvar i = 0; i < 3; i++) begin : g_comp
            localparam int I1 = (i + 1) % 3;
            localparam int I2 = (i + 2) % 3;
            rth_mul #(.AW(W+1), .BW(W+1), .FB(F), .WB(WB)) u_mul_p (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_a   (w_ca[k][I1]),
                .i_b   (w_cb[k][I2]),
                .o_p   (w_cp[k][i])
            );
            rth_mul #(.AW(W+1), .BW(W+1), .FB(F), .WB(WB)) u_mul_m (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_a   (w_ca[k][I2]),
                .i_b   (w_cb[k][I1]),
                .o_p   (w_cm[k][i])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                for (int i = 0; i < 3; i++) begin
                    r_cr[k][i] <= f_sat((WB+1)'(w_cp[k][i]) - (WB+1)'(w_cm[k][i]));
                end
            end
        end
    end

    // dot products: det, normal.tvec, normal.dir, u and v numerators
    always_comb begin
        w_da[0] = r_e1d[3];
        w_db[0] = r_cr[0];
        w_da[1] = r_tvd[3];
        w_db[1] = r_cr[1];
        w_da[2] = w_dirx;
        w_db[2] = r_cr[1];
        w_da[3] = r_tvd[3];
        w_db[3] = r_cr[0];
        w_da[4] = w_dirx;
        w_db[4] = r_cr[2];
    end

    for (genvar d = 0; d < 5; d++) begin : g_dot
        for (genvar i = 0; i < 3; i++) begin : g_comp
            rth_mul #(.AW(W+1), .BW(WB), .FB(F), .WB(WB)) u_mul (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_a   (w_da[d][i]),
                .i_b   (w_db[d][i]),
                .o_p   (w_dp[d][i])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int d = 0; d < 5; d++) begin
                r_s1[d] <= f_sat((WB+1)'(w_dp[d][0]) + (WB+1)'(w_dp[d][1]));
                r_z[d]  <= w_dp[d][2];
                r_dt[d] <= f_sat((WB+1)'(r_s1[d]) + (WB+1)'(r_z[d]));
            end
        end
    end

    // classify
    always_comb begin
        w_a  = -r_dt[1];
        w_un = r_dt[0][WB-1] ? -r_dt[3] : r_dt[3];
        w_vn = r_dt[0][WB-1] ? -r_dt[4] : r_dt[4];
        w_dd = r_dt[0][WB-1] ? -r_dt[0] : r_dt[0];
        w_uv = (WB+1)'(w_un) + (WB+1)'(w_vn);
        if (f_nz(r_dt[0], r_lim) || f_nz(r_dt[2], r_lim)) begin
            w_rsn = REASON_PARALLEL;
        end else if ((w_a != '0) && (w_a[WB-1] != r_dt[2][WB-1])) begin
            w_rsn = REASON_BEHIND;
        end else if (w_un[WB-1] || (w_un > w_dd)) begin
            w_rsn = REASON_U_OUT;
        end else if (w_vn[WB-1] || (w_uv > (WB+1)'(w_dd))) begin
            w_rsn = REASON_V_OUT;
        end else begin
            w_rsn = REASON_HIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rsn[0] <= w_rsn;
            for (int j = 1; j < DIV_LAT; j++) begin
                r_rsn[j] <= r_rsn[j-1];
            end
        end
    end

    // plane point offset along the ray
    for (genvar i = 0; i < 3; i++) begin : g_point
        rth_div #(.CW(W), .WB(WB)) u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (w_a),
            .i_mul (r_dir[i]),
            .i_den (r_dt[2]),
            .o_q   (w_q[i])
        );

        always_comb begin
            w_ps[i] = (W+3)'(r_org[i]) + (W+3)'(w_q[i]);
            if (w_ps[i] > PT_HI) begin
                w_pt[i] = PT_HI[W-1:0];
            end else if (w_ps[i] < PT_LO) begin
                w_pt[i] = PT_LO[W-1:0];
            end else begin
                w_pt[i] = w_ps[i][W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_hit   <= (r_rsn[DIV_LAT-1] == REASON_HIT);
            r_rsn_o <= r_rsn[DIV_LAT-1];
            for (int i = 0; i < 3; i++) begin
                if (r_rsn[DIV_LAT-1] == REASON_PARALLEL || r_rsn[DIV_LAT-1] == REASON_BEHIND) begin
                    r_pt[i] <= '0;
                end else begin
                    r_pt[i] <= w_pt[i];
                end
            end
        end
    end

    `RTH_ASSERT_IMP(a_hit_matches_reason, o_valid, o_hit == (o_reason == REASON_HIT))
    `RTH_ASSERT_IMP(a_rejected_point_zero, o_valid && (o_reason == REASON_PARALLEL || o_reason == REASON_BEHIND), o_point_x == '0 && o_point_y == '0 && o_point_z == '0)
    `RTH_ASSERT_NXT(a_last_stage_delivers, r_vld[NST-2] && w_en, o_valid)
    `RTH_ASSERT_NXT(a_stall_freezes_pipe, !w_en, $stable(r_vld))
endmodule

FILE: sim/ray_triangle_hit_test.sv
// Self-checking testbench for ray_triangle_hit: streams triangles against several ray set-ups
// and checks every result against a fixed-point predictor kept in a small scoreboard class.
// Depends on rtl/rth_pkg.sv and the ray_triangle_hit RTL.
`timescale 1ns / 100ps
module ray_triangle_hit_test;
    import rth_pkg::*;

    localparam int  CW        = 32;
    localparam int  FB        = 16;
    localparam int  ONE       = 1 << FB;
    localparam int  DRAIN     = 60;
    localparam int  MAX_CYCLE = 400000;

    typedef logic signed [CW-1:0]  t_coord;
    typedef logic signed [127:0]   t_wide;
    typedef t_wide                 t_vec [3];
    typedef t_coord                t_tri [9];

    typedef struct packed {
        logic    hit;
        t_reason reason;
        t_coord  px;
        t_coord  py;
        t_coord  pz;
    } t_hit_result;

    class hit_scoreboard;
        t_wide       org [3];
        t_wide       dir [3];
        t_wide       limit;
        t_hit_result pending [$];
        int          errors;

        function new();
            org = '{0, 0, 0};
            dir = '{0, 0, ONE};
            limit = 1;
            errors = 0;
        endfunction

        function void set_reg(t_cfg_index idx, logic [CW-1:0] val);
            case (idx)
                REG_ORIGIN_X:   org[0] = t_coord'(val);
                REG_ORIGIN_Y:   org[1] = t_coord'(val);
                REG_ORIGIN_Z:   org[2] = t_coord'(val);
                REG_DIR_X:      dir[0] = t_coord'(val);
                REG_DIR_Y:      dir[1] = t_coord'(val);
                REG_DIR_Z:      dir[2] = t_coord'(val);
                REG_NEAR_LIMIT: limit = {97'd0, val[30:0]};
                default:        ;
            endcase
        endfunction

        function t_wide clamp(t_wide x, t_wide hi, t_wide lo);
            if (x > hi) return hi;
            if (x < lo) return lo;
            return x;
        endfunction

        function t_wide wsat(t_wide x);
            t_wide m;
            m = (t_wide'(1) <<< 47) - 1;
            return clamp(x, m, -m);
        endfunction

        function t_wide fmul(t_wide a, t_wide b);
            t_wide p;
            p = a * b;
            return wsat(p >>> FB);
        endfunction

        function t_vec cross_prod(t_vec a, t_vec b);
            t_vec c;
            c[0] = wsat(fmul(a[1], b[2]) - fmul(a[2], b[1]));
            c[1] = wsat(fmul(a[2], b[0]) - fmul(a[0], b[2]));
            c[2] = wsat(fmul(a[0], b[1]) - fmul(a[1], b[0]));
            return c;
        endfunction

        function t_wide dot(t_vec a, t_vec b);
            return wsat(wsat(fmul(a[0], b[0]) + fmul(a[1], b[1])) + fmul(a[2], b[2]));
        endfunction

        function bit near_zero(t_wide x);
            return x == 0 || (x < 0 ? -x : x) < limit;
        endfunction

        function t_coord plane_coord(t_wide o, t_wide a, t_wide d, t_wide b);
            t_wide q;
            t_wide cap;
            cap = t_wide'(1) <<< 62;
            q = clamp((a * d) / b, cap, -cap);
            return t_coord'(clamp(o + q, (t_wide'(1) <<< (CW-1)) - 1, -(t_wide'(1) <<< (CW-1))));
        endfunction

        function t_hit_result predict_hit(t_tri t);
            t_hit_result r;
            t_vec  v0, e1, e2, pv, tv, n, qv;
            t_wide det, a, b, un, vn, dd;
            for (int i = 0; i < 3; i++) begin
                v0[i] = t[i];
                e1[i] = t_wide'(t[3+i]) - v0[i];
                e2[i] = t_wide'(t[6+i]) - v0[i];
                tv[i] = org[i] - v0[i];
            end
            r = '0;
            r.reason = REASON_HIT;
            pv  = cross_prod(dir, e2);
            det = dot(e1, pv);
            n   = cross_prod(e1, e2);
            a   = -dot(n, tv);
            b   = dot(n, dir);
            if (near_zero(det) || near_zero(b)) begin
                r.reason = REASON_PARALLEL;
            end else if (a != 0 && ((a < 0) != (b < 0))) begin
                r.reason = REASON_BEHIND;
            end else begin
                r.px = plane_coord(org[0], a, dir[0], b);
                r.py = plane_coord(org[1], a, dir[1], b);
                r.pz = plane_coord(org[2], a, dir[2], b);
                dd = det < 0 ? -det : det;
                un = dot(tv, pv);
                qv = cross_prod(tv, e1);
                vn = dot(dir, qv);
                if (det < 0) begin
                    un = -un;
                    vn = -vn;
                end
                if (un < 0 || un > dd) r.reason = REASON_U_OUT;
                else if (vn < 0 || un + vn > dd) r.reason = REASON_V_OUT;
            end
            r.hit = r.reason == REASON_HIT;
            return r;
        endfunction

        function void note_triangle(t_tri t);
            pending.push_back(predict_hit(t));
        endfunction

        function void check_result(t_hit_result got);
            t_hit_result exp_r;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.hit !== exp_r.hit) begin
                $display("%0t: hit expected %0d actual %0d", $time, exp_r.hit, got.hit);
                errors++;
            end
            if (got.reason !== exp_r.reason) begin
                $display("%0t: reason expected %0d actual %0d", $time, exp_r.reason, got.reason);
                errors++;
            end
            if (got.px !== exp_r.px) begin
                $display("%0t: point_x expected %h actual %h", $time, exp_r.px, got.px);
                errors++;
            end
            if (got.py !== exp_r.py) begin
                $display("%0t: point_y expected %h actual %h", $time, exp_r.py, got.py);
                errors++;
            end
            if (got.pz !== exp_r.pz) begin
                $display("%0t: point_z expected %h actual %h", $time, exp_r.pz, got.pz);
                errors++;
            end
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         i_valid;
    logic         o_stall;
    t_coord       vtx [9];
    logic         o_valid;
    logic         i_stall;
    logic         o_hit;
    t_reason      o_reason;
    t_coord       o_point_x;
    t_coord       o_point_y;
    t_coord       o_point_z;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    t_cfg_index   i_cfg_index;
    logic [CW-1:0] i_cfg_data;

    hit_scoreboard sb;
    int            send_idle_pct;
    int            recv_idle_pct;
    int            cycles;

    ray_triangle_hit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_vertex0_x (vtx[0]),
        .i_vertex0_y (vtx[1]),
        .i_vertex0_z (vtx[2]),
        .i_vertex1_x (vtx[3]),
        .i_vertex1_y (vtx[4]),
        .i_vertex1_z (vtx[5]),
        .i_vertex2_x (vtx[6]),
        .i_vertex2_y (vtx[7]),
        .i_vertex2_z (vtx[8]),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_hit       (o_hit),
        .o_reason    (o_reason),
        .o_point_x   (o_point_x),
        .o_point_y   (o_point_y),
        .o_point_z   (o_point_z),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > MAX_CYCLE) begin
            $display("Test completed with failures");
            $finish;
        end else if (i_rst_n) begin
            if (i_valid && !o_stall) sb.note_triangle(vtx);
            if (o_valid && !i_stall) sb.check_result({o_hit, o_reason, o_point_x, o_point_y, o_point_z});
        end
    end

    task automatic send_triangle(t_tri t);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        vtx = t;
        i_valid = 1'b1;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic release_input();
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic wait_empty();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_index idx, logic [CW-1:0] val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, val);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic load_ray(t_coord ox, t_coord oy, t_coord oz,
                            t_coord dx, t_coord dy, t_coord dz, logic [CW-1:0] lim);
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_ORIGIN_Z, oz);
        write_reg(REG_DIR_X, dx);
        write_reg(REG_DIR_Y, dy);
        write_reg(REG_DIR_Z, dz);
        write_reg(REG_NEAR_LIMIT, lim);
    endtask

    function automatic t_coord units(int lo, int hi);
        return t_coord'($urandom_range(0, (hi - lo) * ONE)) + t_coord'(lo * ONE);
    endfunction

    function automatic t_tri mk_tri(int ax, int ay, int az, int bx, int by, int bz,
                                   int cx, int cy, int cz);
        t_tri t;
        t = '{ax * ONE, ay * ONE, az * ONE, bx * ONE, by * ONE, bz * ONE,
              cx * ONE, cy * ONE, cz * ONE};
        return t;
    endfunction

    function automatic t_tri rand_tri();
        t_tri t;
        t_coord ctr [3];
        int k;
        if ($urandom_range(0, 99) < 20) begin
            foreach (t[i]) t[i] = $urandom;
        end else begin
            k = $urandom_range(0, 6) - 3;
            for (int i = 0; i < 3; i++)
                ctr[i] = t_coord'(sb.org[i] + k * sb.dir[i]);
            foreach (t[i]) t[i] = ctr[i % 3] + units(-4, 4);
        end
        return t;
    endfunction

    task automatic run_directed();
        t_coord mx;
        t_coord mn;
        mx = 32'h7fffffff;
        mn = 32'h80000000;
        send_triangle(mk_tri(-1, -1, 2, 2, -1, 2, -1, 2, 2));
        send_triangle(mk_tri(-1, 2, 2, 2, -1, 2, -1, -1, 2));
        send_triangle(mk_tri(-1, -1, -2, 2, -1, -2, -1, 2, -2));
        send_triangle(mk_tri(0, 0, 0, 1, 0, 0, 0, 0, 1));
        send_triangle(mk_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_triangle(mk_tri(4, -1, 2, 7, -1, 2, 4, 2, 2));
        send_triangle(mk_tri(-6, -1, 2, -3, -1, 2, -6, 2, 2));
        send_triangle(mk_tri(-1, 4, 2, 2, 4, 2, -1, 7, 2));
        send_triangle(mk_tri(1, 1, 3, -1, 1, 1, 1, -1, 1));
        send_triangle(mk_tri(0, 0, 0, 1, 0, 0, 0, 1, 0));
        send_triangle('{mx, mx, mx, mx, mx, mx, mx, mx, mx});
        send_triangle('{mn, mn, mn, mn, mn, mn, mn, mn, mn});
        send_triangle('{mx, mn, mx, mn, mx, mn, mx, mn, mx});
        send_triangle('{mn, mn, mx, mx, mn, mx, mn, mx, mx});
        send_triangle('{mx, mx, mn, mn, mx, mn, 0, 0, mx});
        release_input();
    endtask

    initial begin
        sb = new();
        cycles = 0;
        send_idle_pct = 25;
        recv_idle_pct = 25;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_ORIGIN_X;
        i_cfg_data = '0;
        foreach (vtx[i]) vtx[i] = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        run_directed();
        for (int ph = 0; ph < 8; ph++) begin
            wait_empty();
            if (ph == 0)
                load_ray(32'h7fffffff, 32'h80000000, 32'h7fffffff,
                         32'h80000000, 32'h7fffffff, 32'h80000000, 32'h0);
            else if (ph == 1)
                load_ray(units(-8, 8), units(-8, 8), units(-8, 8),
                         units(-2, 2), units(-2, 2), units(-2, 2), 32'h7fffffff);
            else if (ph == 2)
                load_ray(0, 0, 0, 0, 0, 0, 32'h0);
            else
                load_ray(units(-8, 8), units(-8, 8), units(-8, 8),
                         units(-2, 2), units(-2, 2), units(-2, 2),
                         $urandom_range(0, 4096));
            send_idle_pct = (ph == 4) ? 0 : 25;
            recv_idle_pct = (ph == 4) ? 0 : 25;
            for (int n = 0; n < 175; n++) begin
                if (ph == 3 && n == 90) begin
                    release_input();
                    wait_empty();
                end
                send_triangle(rand_tri());
            end
            release_input();
        end

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
